>>> design/ili_pkg.sv
// Shared constants and types for the interval list intersection block.
package ili_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int VAL_W      = 64;
    localparam int ADDR_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W    = 2 * VAL_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_DEPTH);

    typedef enum logic [1:0] {
        MODE_LOAD_LEFT  = 2'd0,
        MODE_LOAD_RIGHT = 2'd1,
        MODE_INTERSECT  = 2'd2
    } mode_t;

    // One stored interval: lo is inclusive, hi is exclusive.
    typedef struct packed {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } entry_t;

endpackage

>>> design/ili_item_if.sv
// Input channel: one interval load or intersect command per beat.
interface ili_item_if;
    import ili_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [VAL_W-1:0] interval_begin;
    logic [VAL_W-1:0] interval_end;

    modport source (output valid, mode, interval_begin, interval_end, input ready);
    modport sink   (input valid, mode, interval_begin, interval_end, output ready);
endinterface

>>> design/ili_result_if.sv
// Output channel: one intersected interval per beat.
interface ili_result_if;
    import ili_pkg::*;

    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] out_begin;
    logic [VAL_W-1:0] out_end;
    logic             is_last;
    logic             none_found;
    logic             overflow;

    modport source (output valid, out_begin, out_end, is_last, none_found, overflow,
                    input ready);
    modport sink   (input valid, out_begin, out_end, is_last, none_found, overflow,
                    output ready);
endinterface

>>> design/interval_list_intersect_core.sv
// Interval list intersection. Mode 0 and mode 1 beats load one half-open interval
// into the left or right list; a load needs no memory read (the last stored interval
// of each list is kept in registers for merging) and gives no result. A mode 2 beat
// starts a run that walks both list memories with two pointers: each walk step is a
// registered memory read and compare (ST_CALC), then a coalesce (ST_MERGE), and a run
// has at most left_count + right_count - 1 steps; the result side can stall it by
// holding ready low. If either list is empty the run goes straight to ST_FINISH. New
// beats are taken only between runs. The last result of a run has is_last set; an
// empty intersection gives one none_found result. Both lists and the overflow flag
// are cleared when the last result is loaded into the output register.
module interval_list_intersect_core (
    input logic          clk,
    input logic          rst_n,
    ili_item_if.sink     items,
    ili_result_if.source results
);
    import ili_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_MERGE,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] lcnt_reg, lcnt_next;
    logic [CNT_W-1:0] rcnt_reg, rcnt_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             pend_valid_reg, pend_valid_next;
    entry_t           pend_reg, pend_next;
    entry_t           cand_reg, cand_next;
    logic             hit_reg, hit_next;
    entry_t           llast_reg, llast_next;
    entry_t           rlast_reg, rlast_next;
    logic             out_valid_reg, out_valid_next;
    entry_t           out_reg, out_next;
    logic             out_last_reg, out_last_next;
    logic             out_none_reg, out_none_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             load_right;
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] sel_cnt_dec;
    entry_t           sel_last;
    logic             ld_empty;
    logic             ld_merge;
    logic             ld_we;
    logic [ADDR_W-1:0] ld_addr;
    entry_t           ld_data;
    logic             lwe, rwe;
    logic             mem_re;
    entry_t           lrd, rrd;
    logic [ENTRY_W-1:0] lrd_raw, rrd_raw;
    logic             adv_left;
    logic             proceed;
    logic             more;

    assign accept   = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign items.ready        = (state_reg == ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.out_begin  = out_reg.lo;
    assign results.out_end    = out_reg.hi;
    assign results.is_last    = out_last_reg;
    assign results.none_found = out_none_reg;
    assign results.overflow   = out_ovf_reg;

    // Load path, shared by both lists.
    assign load_right  = (mode_t'(items.mode) == MODE_LOAD_RIGHT);
    assign sel_cnt     = load_right ? rcnt_reg : lcnt_reg;
    assign sel_last    = load_right ? rlast_reg : llast_reg;
    assign sel_cnt_dec = sel_cnt - CNT_W'(1);
    assign ld_empty    = (items.interval_begin >= items.interval_end);
    assign ld_merge    = (sel_cnt != '0) && (items.interval_begin <= sel_last.hi);

    assign lrd = entry_t'(lrd_raw);
    assign rrd = entry_t'(rrd_raw);

    // Writes happen only on load beats and reads only on an intersect beat or during a run, so the ports never collide.
    ili_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_left_ram (
        .clk   (clk),
        .we    (lwe),
        .waddr (ld_addr),
        .wdata (ld_data),
        .re    (mem_re),
        .raddr (i_reg[ADDR_W-1:0]),
        .rdata (lrd_raw)
    );

    ili_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_right_ram (
        .clk   (clk),
        .we    (rwe),
        .waddr (ld_addr),
        .wdata (ld_data),
        .re    (mem_re),
        .raddr (j_reg[ADDR_W-1:0]),
        .rdata (rrd_raw)
    );

    assign adv_left = (lrd.hi < rrd.hi);
    assign more     = (i_reg < lcnt_reg) && (j_reg < rcnt_reg);

    always_comb
    begin
        state_next      = state_reg;
        lcnt_next       = lcnt_reg;
        rcnt_next       = rcnt_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cand_next       = cand_reg;
        hit_next        = hit_reg;
        llast_next      = llast_reg;
        rlast_next      = rlast_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        out_ovf_next    = out_ovf_reg;
        out_load        = 1'b0;
        ld_we           = 1'b0;
        ld_addr         = sel_cnt[ADDR_W-1:0];
        ld_data         = '{lo: items.interval_begin, hi: items.interval_end};
        mem_re          = 1'b0;
        proceed         = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(items.mode))
                        MODE_LOAD_LEFT, MODE_LOAD_RIGHT:
                        begin
                            if (!ld_empty)
                            begin
                                priority if (ld_merge)
                                begin
                                    if (items.interval_end > sel_last.hi)
                                    begin
                                        ld_we   = 1'b1;
                                        ld_addr = sel_cnt_dec[ADDR_W-1:0];
                                        ld_data = '{lo: sel_last.lo, hi: items.interval_end};
                                    end
                                end
                                else if (sel_cnt == CNT_FULL)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    ld_we = 1'b1;
                                end
                            end
                            if (ld_we)
                            begin
                                if (load_right)
                                begin
                                    rlast_next = ld_data;
                                    if (!ld_merge)
                                    begin
                                        rcnt_next = rcnt_reg + CNT_W'(1);
                                    end
                                end
                                else
                                begin
                                    llast_next = ld_data;
                                    if (!ld_merge)
                                    begin
                                        lcnt_next = lcnt_reg + CNT_W'(1);
                                    end
                                end
                            end
                        end
                        MODE_INTERSECT:
                        begin
                            if ((lcnt_reg != '0) && (rcnt_reg != '0))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_CALC;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CALC:
            begin
                cand_next.lo = (lrd.lo > rrd.lo) ? lrd.lo : rrd.lo;
                cand_next.hi = adv_left ? lrd.hi : rrd.hi;
                hit_next     = (cand_next.lo < cand_next.hi);
                if (adv_left)
                begin
                    i_next = i_reg + CNT_W'(1);
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                if (hit_reg)
                begin
                    priority if (pend_valid_reg && (cand_reg.lo <= pend_reg.hi))
                    begin
                        // Touching or overlapping the pending result: coalesce.
                        if (cand_reg.hi > pend_reg.hi)
                        begin
                            pend_next.hi = cand_reg.hi;
                        end
                    end
                    else if (pend_valid_reg)
                    begin
                        if (out_free)
                        begin
                            out_load      = 1'b1;
                            out_next      = pend_reg;
                            out_last_next = 1'b0;
                            out_none_next = 1'b0;
                            pend_next     = cand_reg;
                        end
                        else
                        begin
                            proceed = 1'b0;
                        end
                    end
                    else
                    begin
                        pend_valid_next = 1'b1;
                        pend_next       = cand_reg;
                    end
                end
                if (proceed)
                begin
                    if (more)
                    begin
                        mem_re     = 1'b1;
                        state_next = ST_CALC;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_none_next = 1'b0;
                    end
                    else
                    begin
                        out_next      = '0;
                        out_none_next = 1'b1;
                    end
                    lcnt_next       = '0;
                    rcnt_next       = '0;
                    ovf_next        = 1'b0;
                    i_next          = '0;
                    j_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ovf_next   = ovf_reg;
        end
    end

    assign lwe = ld_we && !load_right;
    assign rwe = ld_we && load_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lcnt_reg       <= '0;
            rcnt_reg       <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lcnt_reg       <= lcnt_next;
            rcnt_reg       <= rcnt_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        cand_reg     <= cand_next;
        hit_reg      <= hit_next;
        llast_reg    <= llast_next;
        rlast_reg    <= rlast_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        out_none_reg <= out_none_next;
        out_ovf_reg  <= out_ovf_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= CNT_FULL) && (rcnt_reg <= CNT_FULL))
        else $error("list count beyond capacity");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> ((i_reg < lcnt_reg) && (j_reg < rcnt_reg)))
        else $error("walk pointer read past the end of a list");

    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_reg.lo < pend_reg.hi))
        else $error("pending result is an empty interval");

    a_none_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_none_reg) |->
            (out_last_reg && (out_reg.lo == '0) && (out_reg.hi == '0)))
        else $error("none_found result is malformed");

    a_clear_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && out_free) |=>
            ((lcnt_reg == '0) && (rcnt_reg == '0) && !ovf_reg && (state_reg == ST_IDLE)))
        else $error("lists not cleared after the last result");

endmodule

>>> design/ili_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module ili_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/interval_list_intersect_core_tb.sv
// Self-checking testbench for the interval list intersection core.
`timescale 1ns / 1ps

module interval_list_intersect_core_tb;
    import ili_pkg::*;

    localparam logic [1:0]       MODE_UNUSED  = 2'd3;
    localparam logic [VAL_W-1:0] ALL_ONES     = '1;
    localparam int RANDOM_ITEMS  = 130;
    localparam int QUIET_FROM    = 100;
    localparam int QUIET_TO      = 135;
    localparam int PRESSURE_AT   = 45;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 4 * LIST_DEPTH + 40;
    localparam int CYCLE_LIMIT   = 100000;

    typedef struct {
        logic [1:0]       mode;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } cmd_t;

    typedef struct {
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        logic             last;
        logic             none;
        logic             ovf;
    } overlap_t;

    logic clk;
    logic rst_n = 1'b1;

    ili_item_if   item_ch ();
    ili_result_if result_ch ();

    interval_list_intersect_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (item_ch),
        .results (result_ch)
    );

    // Shadow copy of both interval stores; index 0 is the left list, 1 the right.
    logic [VAL_W-1:0] list_lo [2][LIST_DEPTH];
    logic [VAL_W-1:0] list_hi [2][LIST_DEPTH];
    int unsigned      list_n  [2];
    logic             load_dropped;

    cmd_t     cmd_queue[$];
    overlap_t expected_overlaps[$];

    int sent_beats;
    int beats_by_mode [4];
    int results_checked;
    int empty_runs;
    int overflow_results;
    int errors;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic store_interval(input int side, input logic [VAL_W-1:0] lo,
                                  input logic [VAL_W-1:0] hi);
        int unsigned n;
        n = list_n[side];
        if (lo >= hi)
            return;
        // Overlapping or touching the newest interval extends it; its begin stays.
        if (n > 0 && lo <= list_hi[side][n-1])
        begin
            if (hi > list_hi[side][n-1])
                list_hi[side][n-1] = hi;
            return;
        end
        if (n >= LIST_DEPTH)
        begin
            load_dropped = 1'b1;
            return;
        end
        list_lo[side][n] = lo;
        list_hi[side][n] = hi;
        list_n[side]     = n + 1;
    endtask

    task automatic intersect_lists();
        int unsigned      i;
        int unsigned      j;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] e;
        overlap_t         run[$];
        overlap_t         s;
        i = 0;
        j = 0;
        while (i < list_n[0] && j < list_n[1])
        begin
            b = (list_lo[0][i] > list_lo[1][j]) ? list_lo[0][i] : list_lo[1][j];
            e = (list_hi[0][i] < list_hi[1][j]) ? list_hi[0][i] : list_hi[1][j];
            if (b < e)
            begin
                if (run.size() > 0 && b <= run[run.size()-1].hi)
                begin
                    if (e > run[run.size()-1].hi)
                        run[run.size()-1].hi = e;
                end
                else
                begin
                    s = '{b, e, 1'b0, 1'b0, load_dropped};
                    run.insert(run.size(), s);
                end
            end
            if (list_hi[0][i] < list_hi[1][j])
                i++;
            else
                j++;
        end
        if (run.size() == 0)
        begin
            s = '{'0, '0, 1'b0, 1'b1, load_dropped};
            run.insert(run.size(), s);
        end
        run[run.size()-1].last = 1'b1;
        foreach (run[k])
            expected_overlaps.insert(expected_overlaps.size(), run[k]);
        list_n[0]    = 0;
        list_n[1]    = 0;
        load_dropped = 1'b0;
    endtask

    task automatic apply_beat(input logic [1:0] mode, input logic [VAL_W-1:0] lo,
                              input logic [VAL_W-1:0] hi);
        case (mode)
            MODE_LOAD_LEFT:  store_interval(0, lo, hi);
            MODE_LOAD_RIGHT: store_interval(1, lo, hi);
            MODE_INTERSECT:  intersect_lists();
            default:         ;
        endcase
    endtask

    task automatic add_cmd(input logic [1:0] mode, input logic [VAL_W-1:0] lo,
                           input logic [VAL_W-1:0] hi);
        cmd_t c;
        c = '{mode, lo, hi};
        cmd_queue.insert(cmd_queue.size(), c);
    endtask

    // Ascending lists for both sides, interleaved at random. A zero step gives
    // touching loads (merged) and empty loads (dropped).
    task automatic plan_lists(input int nl, input int nr, input logic [VAL_W-1:0] base,
                              input int min_step, input int max_gap, input int max_len);
        cmd_t             lq[$];
        cmd_t             rq[$];
        cmd_t             c;
        logic [VAL_W-1:0] cur;
        cur = base;
        for (int k = 0; k < nl; k++)
        begin
            cur  = cur + $urandom_range(max_gap, min_step);
            c.mode = MODE_LOAD_LEFT;
            c.lo = cur;
            cur  = cur + $urandom_range(max_len, min_step);
            c.hi = cur;
            lq.insert(lq.size(), c);
        end
        cur = base + $urandom_range(8, 0);
        for (int k = 0; k < nr; k++)
        begin
            cur  = cur + $urandom_range(max_gap, min_step);
            c.mode = MODE_LOAD_RIGHT;
            c.lo = cur;
            cur  = cur + $urandom_range(max_len, min_step);
            c.hi = cur;
            rq.insert(rq.size(), c);
        end
        while (lq.size() > 0 || rq.size() > 0)
        begin
            if (rq.size() == 0 || (lq.size() > 0 && $urandom_range(1) == 0))
                cmd_queue.insert(cmd_queue.size(), lq.pop_front());
            else
                cmd_queue.insert(cmd_queue.size(), rq.pop_front());
        end
    endtask

    task automatic report_field(input string name, input logic [VAL_W-1:0] exp_val,
                                input logic [VAL_W-1:0] act_val);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val,
                 act_val);
    endtask

    // Driver: offers queued commands, idling at random outside the quiet window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid          <= 1'b0;
            item_ch.mode           <= MODE_LOAD_LEFT;
            item_ch.interval_begin <= '0;
            item_ch.interval_end   <= '0;
            list_n[0]              = 0;
            list_n[1]              = 0;
            load_dropped           = 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                apply_beat(item_ch.mode, item_ch.interval_begin, item_ch.interval_end);
                beats_by_mode[item_ch.mode] <= beats_by_mode[item_ch.mode] + 1;
                sent_beats <= sent_beats + 1;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (cmd_queue.size() > 0 &&
                    ((sent_beats >= QUIET_FROM && sent_beats < QUIET_TO) ||
                     $urandom_range(99) >= 33))
                begin
                    item_ch.valid          <= 1'b1;
                    item_ch.mode           <= cmd_queue[0].mode;
                    item_ch.interval_begin <= cmd_queue[0].lo;
                    item_ch.interval_end   <= cmd_queue[0].hi;
                    void'(cmd_queue.pop_front());
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and paces ready, with one long hold-off.
    int hold_left;
    bit pressure_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left       = 0;
            pressure_done   = 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_overlaps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, actual %h..%h",
                             $time, result_ch.out_begin, result_ch.out_end);
                end
                else
                begin
                    if (result_ch.out_begin !== expected_overlaps[0].lo)
                        report_field("out_begin", expected_overlaps[0].lo,
                                     result_ch.out_begin);
                    if (result_ch.out_end !== expected_overlaps[0].hi)
                        report_field("out_end", expected_overlaps[0].hi,
                                     result_ch.out_end);
                    if (result_ch.is_last !== expected_overlaps[0].last)
                        report_field("is_last", VAL_W'(expected_overlaps[0].last),
                                     VAL_W'(result_ch.is_last));
                    if (result_ch.none_found !== expected_overlaps[0].none)
                        report_field("none_found", VAL_W'(expected_overlaps[0].none),
                                     VAL_W'(result_ch.none_found));
                    if (result_ch.overflow !== expected_overlaps[0].ovf)
                        report_field("overflow", VAL_W'(expected_overlaps[0].ovf),
                                     VAL_W'(result_ch.overflow));
                    if (expected_overlaps[0].none)
                        empty_runs <= empty_runs + 1;
                    if (expected_overlaps[0].ovf)
                        overflow_results <= overflow_results + 1;
                    void'(expected_overlaps.pop_front());
                end
                results_checked <= results_checked + 1;
            end
            if (!pressure_done && sent_beats >= PRESSURE_AT)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (sent_beats >= QUIET_FROM && sent_beats < QUIET_TO)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(99) >= 33);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d commands and %0d results outstanding", $time,
                     cmd_queue.size(), expected_overlaps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int               directed_n;
        int               pick;
        logic [VAL_W-1:0] base;
        logic [VAL_W-1:0] lo;

        sent_beats       = 0;
        results_checked  = 0;
        empty_runs       = 0;
        overflow_results = 0;
        errors           = 0;
        cycle_count      = 0;
        foreach (beats_by_mode[m])
            beats_by_mode[m] = 0;
        rst_n <= 1'b0;

        // Directed: empty lists, unused mode, field extremes, empty and merged loads.
        add_cmd(MODE_INTERSECT, '0, '0);
        add_cmd(MODE_UNUSED, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        add_cmd(MODE_LOAD_LEFT, '0, ALL_ONES);
        add_cmd(MODE_LOAD_LEFT, 64'd5, 64'd5);
        add_cmd(MODE_LOAD_LEFT, 64'd9, 64'd3);
        add_cmd(MODE_LOAD_RIGHT, 64'd0, 64'd1);
        add_cmd(MODE_LOAD_RIGHT, 64'd1, 64'd4);
        add_cmd(MODE_LOAD_RIGHT, 64'd2, 64'd3);
        add_cmd(MODE_LOAD_RIGHT, 64'd100, 64'd200);
        add_cmd(MODE_LOAD_RIGHT, 64'd50, 64'd60);
        add_cmd(MODE_LOAD_RIGHT, ALL_ONES - 64'd15, ALL_ONES);
        add_cmd(MODE_INTERSECT, ALL_ONES, '0);
        // Lists that only touch have an empty intersection.
        add_cmd(MODE_LOAD_LEFT, 64'd10, 64'd20);
        add_cmd(MODE_LOAD_RIGHT, 64'd20, 64'd30);
        add_cmd(MODE_INTERSECT, '0, ALL_ONES);
        add_cmd(MODE_LOAD_LEFT, 64'd1, 64'd2);
        add_cmd(MODE_INTERSECT, '0, '0);
        directed_n = cmd_queue.size();

        while (cmd_queue.size() < directed_n + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(1) == 0)
            begin
                base     = {$urandom, $urandom};
                base[63] = 1'b0;
            end
            else
            begin
                base = 64'($urandom_range(40));
            end
            if (pick < 70)
            begin
                plan_lists($urandom_range(6), $urandom_range(6), base, 0, 5, 9);
                add_cmd(MODE_INTERSECT, {$urandom, $urandom}, {$urandom, $urandom});
            end
            else if (pick < 80)
            begin
                // As many separate intervals as a list holds, or more.
                plan_lists($urandom_range(19, 16), $urandom_range(4, 1), base, 1, 4, 7);
                add_cmd(MODE_INTERSECT, {$urandom, $urandom}, {$urandom, $urandom});
            end
            else if (pick < 90)
            begin
                // Loads out of order, some of them empty.
                repeat ($urandom_range(6, 2))
                begin
                    lo = 64'($urandom_range(60));
                    add_cmd(2'($urandom_range(1)), lo, 64'($urandom_range(70)));
                end
                add_cmd(MODE_INTERSECT, '0, '0);
            end
            else
            begin
                repeat ($urandom_range(5, 2))
                    add_cmd(2'($urandom_range(3)), {$urandom, $urandom},
                            {$urandom, $urandom});
            end
        end
        // A final run leaves both lists empty before the drain.
        add_cmd(MODE_INTERSECT, '0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (cmd_queue.size() != 0 || item_ch.valid || expected_overlaps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Beats sent: %0d left loads, %0d right loads, %0d intersect runs, %0d unused",
                 beats_by_mode[0], beats_by_mode[1], beats_by_mode[2], beats_by_mode[3]);
        $display("Result beats checked: %0d, empty intersections %0d, with overflow %0d",
                 results_checked, empty_runs, overflow_results);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
